/* design/i2d_pkg.sv */
// Shared constants and a helper function of the integer to decimal ASCII converter.
package i2d_pkg;

    localparam int DEFAULT_VALUE_BITS = 64;
    localparam int QUEUE_DEPTH        = 2;
    localparam int DIGIT_COUNT        = 20;
    localparam int BCD_BITS           = DIGIT_COUNT * 4;
    localparam int DIGIT_CNT_W        = $clog2(DIGIT_COUNT + 1);

    localparam logic [7:0] ASCII_ZERO  = 8'd48;
    localparam logic [7:0] ASCII_MINUS = 8'd45;
    localparam logic [3:0] BCD_LIMIT   = 4'd5;
    localparam logic [3:0] BCD_ADJUST  = 4'd3;

    // Add three to every BCD digit of five or more ahead of a shift
    function automatic logic [BCD_BITS-1:0] bcd_adjust(input logic [BCD_BITS-1:0] bcd);
        logic [BCD_BITS-1:0] res;
        res = bcd;
        for (int i = 0; i < DIGIT_COUNT; i++) begin
            if (bcd[i*4 +: 4] >= BCD_LIMIT) begin
                res[i*4 +: 4] = bcd[i*4 +: 4] + BCD_ADJUST;
            end
        end
        return res;
    endfunction

endpackage

/* design/i2d_front.sv */
// Front end: takes input transfers and reduces them to a magnitude and a sign flag.
module i2d_front
    import i2d_pkg::*;
#(
    parameter int VALUE_BITS = DEFAULT_VALUE_BITS
) (
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [63:0]           s_tdata,    // [63:0] raw_value
    input  logic                  s_tuser,    // [0] treat_as_signed
    input  logic                  q_full,
    output logic                  q_push,
    output logic [VALUE_BITS:0]   q_wdata     // [VALUE_BITS-1:0] magnitude, [VALUE_BITS] negative
);

    logic [VALUE_BITS-1:0] value;
    logic                  negative;
    logic [VALUE_BITS-1:0] magnitude;

    // Keep only the configured width and take the magnitude of negative values
    always_comb begin
        value     = s_tdata[VALUE_BITS-1:0];
        negative  = s_tuser && value[VALUE_BITS-1];
        magnitude = negative ? (~value + {{(VALUE_BITS-1){1'b0}}, 1'b1}) : value;
    end

    assign s_tready = aresetn && !q_full;
    assign q_push   = s_tvalid && s_tready;
    assign q_wdata  = {negative, magnitude};

endmodule

/* design/i2d_queue.sv */
// Short register queue between the front end and the conversion engine.
module i2d_queue
    import i2d_pkg::*;
#(
    parameter int WIDTH = DEFAULT_VALUE_BITS + 1,
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             full,
    output logic             not_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == CNT_FULL);
    assign not_empty = (count_reg != '0);
    assign rdata     = entry_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store entries
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

/* design/i2d_back.sv */
// Conversion engine: bit-serial double dabble, then character output through a register.
module i2d_back
    import i2d_pkg::*;
#(
    parameter int VALUE_BITS = DEFAULT_VALUE_BITS
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                q_valid,
    input  logic [VALUE_BITS:0] q_rdata,   // [VALUE_BITS-1:0] magnitude, [VALUE_BITS] negative
    output logic                q_pop,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [7:0]          m_tdata,   // [7:0] ascii_char
    output logic                m_tlast
);

    localparam int BIT_CNT_W = $clog2(VALUE_BITS);
    localparam logic [BIT_CNT_W-1:0] BIT_CNT_TOP = BIT_CNT_W'(VALUE_BITS - 1);
    localparam logic [DIGIT_CNT_W-1:0] DIGITS_ALL = DIGIT_CNT_W'(DIGIT_COUNT);
    localparam logic [DIGIT_CNT_W-1:0] DIGITS_ONE = DIGIT_CNT_W'(1);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_CONV = 3'd1;
    localparam logic [2:0] ST_SKIP = 3'd2;
    localparam logic [2:0] ST_SIGN = 3'd3;
    localparam logic [2:0] ST_EMIT = 3'd4;

    logic [2:0]             state_reg, state_next;
    logic [VALUE_BITS-1:0]  bin_reg, bin_next;
    logic [BCD_BITS-1:0]    bcd_reg, bcd_next;
    logic [BIT_CNT_W-1:0]   bit_cnt_reg, bit_cnt_next;
    logic [DIGIT_CNT_W-1:0] left_reg, left_next;
    logic                   neg_reg, neg_next;
    logic                   out_valid_reg, out_valid_next;
    logic [7:0]             out_char_reg, out_char_next;
    logic                   out_last_reg, out_last_next;

    logic                   slot_free;
    logic [3:0]             top_digit;
    logic [BCD_BITS-1:0]    bcd_adj;

    assign slot_free = !out_valid_reg || m_tready;
    assign top_digit = bcd_reg[BCD_BITS-1 -: 4];
    assign bcd_adj   = bcd_adjust(bcd_reg);

    always_comb begin
        state_next     = state_reg;
        bin_next       = bin_reg;
        bcd_next       = bcd_reg;
        bit_cnt_next   = bit_cnt_reg;
        left_next      = left_reg;
        neg_next       = neg_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;
        q_pop          = 1'b0;

        unique case (state_reg)
            // Load the next queued magnitude
            ST_IDLE: begin
                if (q_valid) begin
                    q_pop        = 1'b1;
                    bin_next     = q_rdata[VALUE_BITS-1:0];
                    neg_next     = q_rdata[VALUE_BITS];
                    bcd_next     = '0;
                    bit_cnt_next = BIT_CNT_TOP;
                    state_next   = ST_CONV;
                end
            end
            // Shift one binary bit into the BCD register per cycle
            ST_CONV: begin
                bcd_next = {bcd_adj[BCD_BITS-2:0], bin_reg[VALUE_BITS-1]};
                bin_next = bin_reg << 1;
                bit_cnt_next = bit_cnt_reg - 1'b1;
                if (bit_cnt_reg == '0) begin
                    left_next  = DIGITS_ALL;
                    state_next = ST_SKIP;
                end
            end
            // Drop leading zero digits, keeping at least one
            ST_SKIP: begin
                if (top_digit == 4'd0 && left_reg != DIGITS_ONE) begin
                    bcd_next  = bcd_reg << 4;
                    left_next = left_reg - 1'b1;
                end else begin
                    state_next = neg_reg ? ST_SIGN : ST_EMIT;
                end
            end
            // Send the minus sign
            ST_SIGN: begin
                if (slot_free) begin
                    out_valid_next = 1'b1;
                    out_char_next  = ASCII_MINUS;
                    out_last_next  = 1'b0;
                    state_next     = ST_EMIT;
                end
            end
            // Send digits, most significant first
            ST_EMIT: begin
                if (slot_free) begin
                    out_valid_next = 1'b1;
                    out_char_next  = ASCII_ZERO + {4'd0, top_digit};
                    out_last_next  = (left_reg == DIGITS_ONE);
                    bcd_next       = bcd_reg << 4;
                    left_next      = left_reg - 1'b1;
                    if (left_reg == DIGITS_ONE) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold datapath and output payload
    always_ff @(posedge aclk) begin
        bin_reg      <= bin_next;
        bcd_reg      <= bcd_next;
        bit_cnt_reg  <= bit_cnt_next;
        left_reg     <= left_next;
        neg_reg      <= neg_next;
        out_char_reg <= out_char_next;
        out_last_reg <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_char_reg;
    assign m_tlast  = out_last_reg;

endmodule

/* design/integer_to_decimal_ascii.sv */
// Top level of the integer to decimal ASCII converter.
//
// Slave channel: one transfer carries a value (tdata[63:0]) and a signed
// flag (tuser); only the low VALUE_BITS bits of the value are used.
// Master channel: one transfer per character, most significant digit
// first, preceded by '-' for a negative signed value; tlast marks the
// final character. Zero gives a single '0'.
// A two-entry queue separates input from the conversion engine, so up to
// two further values are taken while one is being converted.
// Per value the engine loads it, runs double dabble at one bit per cycle,
// drops leading zero digits, keeping at least one (up to 20 digit
// positions in all), then sends one character at a time through the
// output register. A stalled receiver holds the output register and
// the engine; input is refused only once the queue is full.
// Reset clears the queue and the engine; no characters are pending after it.
module integer_to_decimal_ascii
    import i2d_pkg::*;
#(
    parameter int VALUE_BITS = DEFAULT_VALUE_BITS
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [63:0] raw_value
    input  logic        s_tuser,   // [0] treat_as_signed
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] ascii_char
    output logic        m_tlast    // last_char
);

    logic                q_full;
    logic                q_push;
    logic                q_pop;
    logic                q_valid;
    logic [VALUE_BITS:0] q_wdata;
    logic [VALUE_BITS:0] q_rdata;

    i2d_front #(
        .VALUE_BITS(VALUE_BITS)
    ) u_front (
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_wdata  (q_wdata)
    );

    i2d_queue #(
        .WIDTH(VALUE_BITS + 1),
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .wdata     (q_wdata),
        .pop       (q_pop),
        .rdata     (q_rdata),
        .full      (q_full),
        .not_empty (q_valid)
    );

    i2d_back #(
        .VALUE_BITS(VALUE_BITS)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_rdata  (q_rdata),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule
